// File: sv/rmfh_pkg.sv
// ----------------------------------------------------------------------------
// rmfh_pkg
// Shared types, widths and status codes of the recursive mutex lock unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rmfh_pkg;

  // Fixed field widths of the request and response items.
  localparam int CMD_W    = 1;
  localparam int TID_W    = 4;
  localparam int STATUS_W = 3;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_THREADS = 16;
  localparam int DEF_COUNT_BITS  = 8;

  // Request opcodes.
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_ACQUIRED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REACQUIRED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_STILL_HELD = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_HANDOFF    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd6;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // register the accepted request and read the queue head
    logic execute;  // update the lock state and load the response register
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: sv/rmfh_req_if.sv
// ----------------------------------------------------------------------------
// rmfh_req_if
// Request channel: one acquire or release item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmfh_req_if
  import rmfh_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [TID_W-1:0] thread_id;

  modport source (output valid, output cmd, output thread_id, input ready);
  modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

`default_nettype wire

// File: sv/rmfh_rsp_if.sv
// ----------------------------------------------------------------------------
// rmfh_rsp_if
// Response channel: one result item per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmfh_rsp_if
  import rmfh_pkg::*;
#(
  parameter int MAX_THREADS = DEF_MAX_THREADS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic                  wake_valid;
  logic [TID_W-1:0]      wake_thread;
  logic                  owner_valid;
  logic [TID_W-1:0]      owner_thread;
  logic [COUNT_BITS-1:0] hold_depth;
  logic [CNT_W-1:0]      waiting_count;

  modport source (
    output valid, output status, output wake_valid, output wake_thread,
    output owner_valid, output owner_thread, output hold_depth,
    output waiting_count, input ready
  );
  modport sink (
    input valid, input status, input wake_valid, input wake_thread,
    input owner_valid, input owner_thread, input hold_depth,
    input waiting_count, output ready
  );
endinterface

`default_nettype wire

// File: sv/recursive_mutex_fifo_handoff_unit.sv
// ----------------------------------------------------------------------------
// recursive_mutex_fifo_handoff_unit
// Recursive lock with a FIFO of waiters and direct handoff on final release.
// ----------------------------------------------------------------------------
// Each request passes through two steps: capture registers it and reads the
// waiter at the queue head from the queue memory (registered read port), and
// execute updates owner, hold count and queue pointers and loads the response
// register. The request channel is ready again in the cycle after that, so
// a new request is taken while the previous response still waits; if that
// response is still not taken when the next one is ready, the unit waits
// in its execute step. No new request is taken until the last is executed.
// ----------------------------------------------------------------------------
`default_nettype none

module recursive_mutex_fifo_handoff_unit
  import rmfh_pkg::*;
#(
  parameter int MAX_THREADS = DEF_MAX_THREADS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
)(
  input  wire logic clk,
  input  wire logic rst,
  rmfh_req_if.sink  req,
  rmfh_rsp_if.source rsp
);

  dp_cmd_t dp_cmd;

  rmfh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  rmfh_dp #(
    .MAX_THREADS (MAX_THREADS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .dp_cmd        (dp_cmd),
    .in_cmd        (req.cmd),
    .in_thread_id  (req.thread_id),
    .status        (rsp.status),
    .wake_valid    (rsp.wake_valid),
    .wake_thread   (rsp.wake_thread),
    .owner_valid   (rsp.owner_valid),
    .owner_thread  (rsp.owner_thread),
    .hold_depth    (rsp.hold_depth),
    .waiting_count (rsp.waiting_count)
  );

endmodule

`default_nettype wire

// File: sv/rmfh_ctrl.sv
// ----------------------------------------------------------------------------
// rmfh_ctrl
// Controller: sequences each request through capture and execute and owns
// the valid/ready handshakes of both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module rmfh_ctrl
  import rmfh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      dp_cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  // The response register can be loaded when empty or being emptied.
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    dp_cmd.capture = 1'b0;
    dp_cmd.execute = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          dp_cmd.execute = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and response valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.execute) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A new response is never loaded over one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !dp_cmd.execute)
    else $error("response overwritten while stalled");

  // Every captured request is executed before another is captured.
  a_capture_then_exec: assert property (@(posedge clk) disable iff (rst)
    dp_cmd.capture |=> !dp_cmd.capture)
    else $error("request captured twice without execution");

  // Capture and execute never coincide.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(dp_cmd.capture && dp_cmd.execute))
    else $error("capture and execute in the same cycle");

endmodule

`default_nettype wire

// File: sv/rmfh_dp.sv
// ----------------------------------------------------------------------------
// rmfh_dp
// Datapath: lock owner, hold count, waiter queue memory and the response
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module rmfh_dp
  import rmfh_pkg::*;
#(
  parameter int MAX_THREADS = DEF_MAX_THREADS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
)(
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire dp_cmd_t                             dp_cmd,
  input  wire logic [CMD_W-1:0]                    in_cmd,
  input  wire logic [TID_W-1:0]                    in_thread_id,
  output logic [STATUS_W-1:0]                      status,
  output logic                                     wake_valid,
  output logic [TID_W-1:0]                         wake_thread,
  output logic                                     owner_valid,
  output logic [TID_W-1:0]                         owner_thread,
  output logic [COUNT_BITS-1:0]                    hold_depth,
  output logic [$clog2(MAX_THREADS + 1)-1:0]       waiting_count
);

  localparam int PTR_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_THREADS - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_THREADS);
  localparam logic [COUNT_BITS-1:0] DEPTH_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] DEPTH_MAX = '1;

  // Lock state.
  logic                  held;
  logic [TID_W-1:0]      owner;
  logic [COUNT_BITS-1:0] depth;
  logic [PTR_W-1:0]      head;
  logic [PTR_W-1:0]      tail;
  logic [CNT_W-1:0]      count;

  logic                  held_next;
  logic [TID_W-1:0]      owner_next;
  logic [COUNT_BITS-1:0] depth_next;
  logic [CNT_W-1:0]      count_next;
  logic                  push;
  logic                  pop;
  logic [STATUS_W-1:0]   status_next;
  logic                  wake_next;

  // Captured request and the waiter at the queue head.
  logic [CMD_W-1:0]      cmd_r;
  logic [TID_W-1:0]      tid_r;
  logic [TID_W-1:0]      head_tid;

  logic [TID_W-1:0]      wait_mem [MAX_THREADS];

  // Decide the outcome of the captured request.
  always_comb begin
    held_next   = held;
    owner_next  = owner;
    depth_next  = depth;
    count_next  = count;
    push        = 1'b0;
    pop         = 1'b0;
    wake_next   = 1'b0;
    status_next = ST_FULL;
    if (cmd_r == CMD_ACQUIRE) begin
      if (held && owner == tid_r) begin
        if (depth == DEPTH_MAX) begin
          status_next = ST_FULL;
        end else begin
          depth_next  = depth + DEPTH_ONE;
          status_next = ST_REACQUIRED;
        end
      end else if (!held) begin
        held_next   = 1'b1;
        owner_next  = tid_r;
        depth_next  = DEPTH_ONE;
        status_next = ST_ACQUIRED;
      end else if (count == CNT_FULL) begin
        status_next = ST_FULL;
      end else begin
        push        = 1'b1;
        count_next  = count + CNT_W'(1);
        status_next = ST_QUEUED;
      end
    end else begin
      if (!held || owner != tid_r) begin
        status_next = ST_NOT_OWNER;
      end else if (depth > DEPTH_ONE) begin
        depth_next  = depth - DEPTH_ONE;
        status_next = ST_STILL_HELD;
      end else if (count == '0) begin
        held_next   = 1'b0;
        owner_next  = '0;
        depth_next  = '0;
        status_next = ST_FREED;
      end else begin
        pop         = 1'b1;
        count_next  = count - CNT_W'(1);
        owner_next  = head_tid;
        depth_next  = DEPTH_ONE;
        wake_next   = 1'b1;
        status_next = ST_HANDOFF;
      end
    end
  end

  // Waiter queue memory: written at the tail, read at the head on capture.
  always_ff @(posedge clk) begin
    if (dp_cmd.execute && push) begin
      wait_mem[tail] <= tid_r;
    end
    if (dp_cmd.capture) begin
      head_tid <= wait_mem[head];
    end
  end

  // Request capture register.
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      cmd_r <= in_cmd;
      tid_r <= in_thread_id;
    end
  end

  // Lock state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      held  <= 1'b0;
      owner <= '0;
      depth <= '0;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (dp_cmd.execute) begin
      held  <= held_next;
      owner <= owner_next;
      depth <= depth_next;
      count <= count_next;
      if (push) begin
        tail <= (tail == PTR_LAST) ? '0 : tail + PTR_W'(1);
      end
      if (pop) begin
        head <= (head == PTR_LAST) ? '0 : head + PTR_W'(1);
      end
    end
  end

  // Response register; a freed lock already carries zero owner and depth.
  always_ff @(posedge clk) begin
    if (dp_cmd.execute) begin
      status        <= status_next;
      wake_valid    <= wake_next;
      wake_thread   <= wake_next ? head_tid : '0;
      owner_valid   <= held_next;
      owner_thread  <= owner_next;
      hold_depth    <= depth_next;
      waiting_count <= count_next;
    end
  end

  // The queue never holds more waiters than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("waiter count beyond queue size");

  // Nobody waits on a free lock.
  a_waiters_need_owner: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> held)
    else $error("waiters queued on a free lock");

  // A held lock always has a nonzero count; a free one is fully cleared.
  a_depth_consistent: assert property (@(posedge clk) disable iff (rst)
    held ? (depth != '0) : (depth == '0 && owner == '0))
    else $error("hold count inconsistent with lock state");

  // A handoff always removes exactly one waiter.
  a_handoff_pops: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.execute && pop) |=> count == $past(count) - CNT_W'(1))
    else $error("handoff did not dequeue a waiter");

endmodule

`default_nettype wire
